FILE: rtl/core/nlt_pkg.sv
// shared constants, types and codes for the node liveness tracker
package nlt_pkg;

  // node table size and derived index width
  localparam int NODES  = 16;
  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;

  // field widths
  localparam int ADDR_W  = 5;
  localparam int IDX_W   = 5;
  localparam int STATE_W = 2;
  localparam int POS_W   = 4;
  localparam int AGE_W   = 8;
  localparam int THR_W   = 8;

  // apb port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register indexes, decoded from paddr[2]
  localparam logic REG_OFFLINE = 1'b0;
  localparam logic REG_CLOSED  = 1'b1;

  // reset values
  localparam logic [THR_W-1:0] OFFLINE_THR_RESET = THR_W'(10);
  localparam logic [THR_W-1:0] CLOSED_THR_RESET  = THR_W'(20);
  localparam logic [AGE_W-1:0] AGE_RESET         = AGE_W'(21);
  localparam logic [AGE_W-1:0] AGE_MAX           = {AGE_W{1'b1}};

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // node status codes
  typedef enum logic [STATE_W-1:0] {
    ST_RUNNING = 2'd0,
    ST_OFFLINE = 2'd1,
    ST_CLOSED  = 2'd2
  } node_st_t;

  // classified packet handed from front to back
  typedef struct packed {
    logic              bad;
    logic              hit;
    logic [NODE_W-1:0] target;
  } cmd_t;

  // threshold settings
  typedef struct packed {
    logic [THR_W-1:0] offline;
    logic [THR_W-1:0] closed;
  } thr_t;

  // queue status toward the back end
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

FILE: rtl/core/nlt_front.sv
// front end: takes packets and classifies their addresses into commands
module nlt_front (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [nlt_pkg::ADDR_W-1:0] in_node_address,
  input  logic                      q_full,
  output logic                      push,
  output nlt_pkg::cmd_t             push_cmd
);
  import nlt_pkg::*;

  logic bad;
  logic nonzero;

  // address zero is ignored, anything above the table is flagged
  assign bad     = in_node_address > ADDR_W'(NODES);
  assign nonzero = in_node_address != '0;

  always_comb begin
    push_cmd.bad    = bad;
    push_cmd.hit    = nonzero && !bad;
    push_cmd.target = NODE_W'(in_node_address - ADDR_W'(1));
  end

  // handshake toward the queue
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

FILE: rtl/core/nlt_queue.sv
// short command queue decoupling the front end from the sweep engine
module nlt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  nlt_pkg::cmd_t   push_cmd,
  input  logic            pop,
  output nlt_pkg::cmd_t   head_cmd,
  output nlt_pkg::q_stat_t stat
);
  import nlt_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  // pointer wrap
  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign stat.empty = cnt_r == '0;
  assign stat.full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign head_cmd   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue read while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

FILE: rtl/core/nlt_back.sv
// sweep engine: ages, clears and classifies one node per cycle unless out_stall holds it, with output register
module nlt_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nlt_pkg::thr_t               thr,
  input  nlt_pkg::cmd_t               head_cmd,
  input  nlt_pkg::q_stat_t            q_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nlt_pkg::IDX_W-1:0]   out_node_index,
  output logic [nlt_pkg::STATE_W-1:0] out_node_state,
  output logic [nlt_pkg::POS_W-1:0]   out_active_position,
  output logic [nlt_pkg::AGE_W-1:0]   out_node_age,
  output logic                        out_bad_address,
  output logic                        out_last_node
);
  import nlt_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE,
    S_SWEEP
  } fsm_t;

  fsm_t              fsm_r;
  cmd_t              cmd_r;
  logic [NODE_W-1:0] node_r;
  logic [POS_W-1:0]  act_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  idx_r;
  node_st_t          state_r;
  logic [POS_W-1:0]  pos_r;
  logic [AGE_W-1:0]  age_out_r;
  logic              bad_r;
  logic              last_r;

  logic [AGE_W-1:0]  ages_r  [NODES];
  node_st_t          states_r[NODES];

  logic [AGE_W-1:0]  cur_age;
  node_st_t          cur_st;
  logic [AGE_W-1:0]  inc_age;
  logic [AGE_W-1:0]  new_age;
  node_st_t          new_st;
  logic [POS_W-1:0]  new_pos;
  logic              is_last;
  logic              adv;

  // pull the next command when idle
  assign pop = (fsm_r == S_IDLE) && !q_stat.empty;

  // advance one node when the output register is free or being taken
  assign adv = (fsm_r == S_SWEEP) && (!out_valid_r || !out_stall);

  assign is_last = node_r == NODE_W'(NODES - 1);

  // per-node update: age, clear on hit, classify
  always_comb begin
    cur_age = ages_r[node_r];
    cur_st  = states_r[node_r];
    inc_age = ((cur_st != ST_CLOSED) && (cur_age != AGE_MAX)) ?
              cur_age + AGE_W'(1) : cur_age;
    new_age = (cmd_r.hit && (cmd_r.target == node_r)) ? '0 : inc_age;
    new_pos = '0;
    if (new_age > thr.closed) begin
      new_st = ST_CLOSED;
    end else if (new_age > thr.offline) begin
      new_st = ST_OFFLINE;
    end else begin
      new_st  = ST_RUNNING;
      new_pos = act_r;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      node_r      <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: set on each node, cleared once taken
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (fsm_r)
        S_IDLE: begin
          if (pop) begin
            cmd_r  <= head_cmd;
            node_r <= '0;
            act_r  <= '0;
            fsm_r  <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (adv) begin
            idx_r       <= IDX_W'(node_r) + IDX_W'(1);
            state_r     <= new_st;
            pos_r       <= new_pos;
            age_out_r   <= new_age;
            bad_r       <= cmd_r.bad;
            last_r      <= is_last;
            if (new_st == ST_RUNNING) begin
              act_r <= act_r + POS_W'(1);
            end
            if (is_last) begin
              fsm_r <= S_IDLE;
            end else begin
              node_r <= node_r + NODE_W'(1);
            end
          end
        end
        default: fsm_r <= S_IDLE;
      endcase
    end
  end

  // node table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        ages_r[i]   <= AGE_RESET;
        states_r[i] <= ST_CLOSED;
      end
    end else if (adv) begin
      ages_r[node_r]   <= new_age;
      states_r[node_r] <= new_st;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_node_index      = idx_r;
  assign out_node_state      = state_r;
  assign out_active_position = pos_r;
  assign out_node_age        = age_out_r;
  assign out_bad_address     = bad_r;
  assign out_last_node       = last_r;

`ifndef NO_ASSERTIONS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (fsm_r == S_SWEEP) && (node_r == '0))
    else $error("sweep did not start at first node");
  a_last_ends_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_last) |=> (fsm_r == S_IDLE) && out_valid_r && last_r)
    else $error("last node did not close the sweep");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !adv)
    else $error("result overwritten while stalled");
`endif

endmodule

FILE: rtl/core/node_liveness_tracker.sv
// node liveness tracker top level: config registers, front end, queue, sweep engine
//
//  channel  direction  handshake                     payload
//  in       input      in_valid / in_stall           in_node_address
//  out      output     out_valid / out_stall         index, state, position, age, bad, last
//  cfg      input      psel penable pwrite pready    paddr, pwdata, prdata
//
//  each packet produces NODES results, one per cycle while out_stall is low, once the
//  idle back end fetches it from the queue; the next packet waits for the sweep to end.
//  rst_n is synchronous: ages reset to 21, all nodes closed, thresholds 10 and 20.
//  a stalled output holds the sweep; the two-entry queue keeps taking packets until full.
module node_liveness_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nlt_pkg::ADDR_W-1:0]  in_node_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nlt_pkg::IDX_W-1:0]   out_node_index,
  output logic [nlt_pkg::STATE_W-1:0] out_node_state,
  output logic [nlt_pkg::POS_W-1:0]   out_active_position,
  output logic [nlt_pkg::AGE_W-1:0]   out_node_age,
  output logic                        out_bad_address,
  output logic                        out_last_node,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nlt_pkg::APB_AW-1:0]  paddr,
  input  logic [nlt_pkg::APB_DW-1:0]  pwdata,
  output logic [nlt_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import nlt_pkg::*;

  thr_t    thr_r;
  logic    wr_en;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head_cmd;
  q_stat_t q_stat;

  // config registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.offline <= OFFLINE_THR_RESET;
      thr_r.closed  <= CLOSED_THR_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_OFFLINE: thr_r.offline <= pwdata[THR_W-1:0];
        REG_CLOSED:  thr_r.closed  <= pwdata[THR_W-1:0];
        default:     ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      REG_OFFLINE: prdata = APB_DW'(thr_r.offline);
      REG_CLOSED:  prdata = APB_DW'(thr_r.closed);
      default:     prdata = '0;
    endcase
  end

  nlt_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_node_address (in_node_address),
    .q_full          (q_stat.full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  nlt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  nlt_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .thr                 (thr_r),
    .head_cmd            (head_cmd),
    .q_stat              (q_stat),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_node_index      (out_node_index),
    .out_node_state      (out_node_state),
    .out_active_position (out_active_position),
    .out_node_age        (out_node_age),
    .out_bad_address     (out_bad_address),
    .out_last_node       (out_last_node)
  );

endmodule
